// ----- sv/rfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational fraction ALU package
// Shared codes, command and status types for the controller and datapath.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DIGIT_W         = 8;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_SUB = 3'd1;
  localparam logic [2:0] REQ_MUL = 3'd2;
  localparam logic [2:0] REQ_DIV = 3'd3;
  localparam logic [2:0] REQ_GT  = 3'd4;
  localparam logic [2:0] REQ_GE  = 3'd5;
  localparam logic [2:0] REQ_LT  = 3'd6;
  localparam logic [2:0] REQ_LE  = 3'd7;

  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_LATCH    = 4'd1;
  localparam logic [3:0] ACT_MUL_LOAD = 4'd2;
  localparam logic [3:0] ACT_MUL_STEP = 4'd3;
  localparam logic [3:0] ACT_MUL_FIX  = 4'd4;
  localparam logic [3:0] ACT_FORM     = 4'd5;
  localparam logic [3:0] ACT_SWAP     = 4'd6;
  localparam logic [3:0] ACT_DIV_LOAD = 4'd7;
  localparam logic [3:0] ACT_DIV_STEP = 4'd8;
  localparam logic [3:0] ACT_DIV_END  = 4'd9;
  localparam logic [3:0] ACT_OUT      = 4'd10;

  localparam logic [1:0] PROD_A = 2'd0;
  localparam logic [1:0] PROD_B = 2'd1;
  localparam logic [1:0] PROD_C = 2'd2;

  localparam logic [1:0] DIV_REM  = 2'd0;
  localparam logic [1:0] DIV_QNUM = 2'd1;
  localparam logic [1:0] DIV_QDEN = 2'd2;

  typedef struct packed {
    logic [3:0] act;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic op_cmp;
    logic a_zero;
    logic b_zero;
    logic a_lt_b;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/rfa_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational fraction ALU request channel
// Valid/ready channel carrying the opcode and two fractions.
// ----------------------------------------------------------------------------
interface rfa_in_if #(
  parameter int VALUE_WIDTH = rfa_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    req_type;
  logic signed [VALUE_WIDTH-1:0] first_numerator;
  logic signed [VALUE_WIDTH-1:0] first_denominator;
  logic signed [VALUE_WIDTH-1:0] second_numerator;
  logic signed [VALUE_WIDTH-1:0] second_denominator;

  modport source (
    output valid, req_type, first_numerator, first_denominator,
           second_numerator, second_denominator,
    input  ready
  );

  modport sink (
    input  valid, req_type, first_numerator, first_denominator,
           second_numerator, second_denominator,
    output ready
  );
endinterface
`default_nettype wire

// ----- sv/rfa_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational fraction ALU result channel
// Valid/ready channel carrying the reduced fraction and flags.
// ----------------------------------------------------------------------------
interface rfa_out_if #(
  parameter int VALUE_WIDTH = rfa_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_numerator;
  logic signed [VALUE_WIDTH-1:0] result_denominator;
  logic                          compare_true;
  logic                          overflow;
  logic                          zero_denominator;

  modport source (
    output valid, result_numerator, result_denominator, compare_true,
           overflow, zero_denominator,
    input  ready
  );

  modport sink (
    input  valid, result_numerator, result_denominator, compare_true,
           overflow, zero_denominator,
    output ready
  );
endinterface
`default_nettype wire

// ----- sv/rfa_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational fraction ALU datapath
// Digit-serial multiplier, cross-product combine, Euclid remainder loop and
// restoring divider, result register. Driven one action per cycle.
// ----------------------------------------------------------------------------
module rfa_dpath #(
  parameter int VALUE_WIDTH = rfa_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire rfa_pkg::cmd_t                 cmd,
  output rfa_pkg::stat_t                     st,
  input  wire logic [2:0]                    req_type,
  input  wire logic signed [VALUE_WIDTH-1:0] first_numerator,
  input  wire logic signed [VALUE_WIDTH-1:0] first_denominator,
  input  wire logic signed [VALUE_WIDTH-1:0] second_numerator,
  input  wire logic signed [VALUE_WIDTH-1:0] second_denominator,
  output logic signed [VALUE_WIDTH-1:0]      result_numerator,
  output logic signed [VALUE_WIDTH-1:0]      result_denominator,
  output logic                               compare_true,
  output logic                               overflow,
  output logic                               zero_denominator
);

  localparam int W  = VALUE_WIDTH;
  localparam int DW = rfa_pkg::DIGIT_W;
  localparam int PW = ((W + DW - 1) / DW) * DW;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [2:0]      op_r;
  logic [W-1:0]    n1_r, d1_r, n2_r, d2_r;
  logic [PW-1:0]   mcand_r, mplier_r;
  logic [2*PW-1:0] acc_r;
  logic            mneg_r;
  logic [W-1:0]    pa_r, pb_r, pc_r;
  logic            ova_r, ovb_r, ovc_r;
  logic [W-1:0]    num_r, den_r, a_r, b_r;
  logic            ov_r, cmp_r;
  logic [W-1:0]    dvs_r, rem_r, quo_r;
  logic            qneg_r;
  logic [W-1:0]    out_num_r, out_den_r;
  logic            out_cmp_r, out_ov_r, out_zden_r;

  logic [W-1:0]       mul_x, mul_y;
  logic [PW+DW-1:0]   pp, mul_sum;
  logic [2*PW+DW-1:0] acc_cat;
  logic [2*PW-1:0]    prod;
  logic               prod_ov;
  logic [W-1:0]       sum, diff, form_num, form_den;
  logic               add_ov, sub_ov, lt_lr, lt_rl, op_cmp, form_ov, form_cmp;
  logic [W:0]         div_t, div_sub;
  logic               div_ge;
  logic [W-1:0]       rem_next, mag_a, mag_b, div_dvd, div_dvs, div_src, div_res;
  logic               div_neg;

  always_comb begin
    unique case (cmd.sel)
      rfa_pkg::PROD_A: begin
        mul_x = n1_r;
        mul_y = (op_r == rfa_pkg::REQ_MUL) ? n2_r : d2_r;
      end
      rfa_pkg::PROD_B: begin
        mul_x = d1_r;
        mul_y = n2_r;
      end
      default: begin
        mul_x = d1_r;
        mul_y = d2_r;
      end
    endcase
  end

  assign pp      = {{DW{1'b0}}, mcand_r} * {{PW{1'b0}}, mplier_r[DW-1:0]};
  assign mul_sum = {{DW{1'b0}}, acc_r[2*PW-1:PW]} + pp;
  assign acc_cat = {mul_sum, acc_r[PW-1:0]};
  assign prod    = mneg_r ? (~acc_r + 1'b1) : acc_r;
  assign prod_ov = !((&prod[2*W-1:W-1]) || !(|prod[2*W-1:W-1]));

  assign op_cmp = op_r[2];
  assign sum    = pa_r + pb_r;
  assign diff   = pa_r - pb_r;
  assign add_ov = (pa_r[W-1] == pb_r[W-1]) && (sum[W-1] != pa_r[W-1]);
  assign sub_ov = (pa_r[W-1] != pb_r[W-1]) && (diff[W-1] != pa_r[W-1]);
  assign lt_lr  = $signed(pa_r) < $signed(pb_r);
  assign lt_rl  = $signed(pb_r) < $signed(pa_r);

  always_comb begin
    unique case (op_r)
      rfa_pkg::REQ_ADD: form_num = sum;
      rfa_pkg::REQ_SUB: form_num = diff;
      default:          form_num = pa_r;
    endcase
    form_den = (op_r == rfa_pkg::REQ_DIV) ? pb_r : pc_r;
    form_ov  = ova_r
             | ((op_r != rfa_pkg::REQ_MUL) & ovb_r)
             | (!op_cmp & (op_r != rfa_pkg::REQ_DIV) & ovc_r)
             | ((op_r == rfa_pkg::REQ_ADD) & add_ov)
             | ((op_r == rfa_pkg::REQ_SUB) & sub_ov);
    unique case (op_r)
      rfa_pkg::REQ_GT: form_cmp = lt_rl;
      rfa_pkg::REQ_GE: form_cmp = !lt_lr;
      rfa_pkg::REQ_LT: form_cmp = lt_lr;
      rfa_pkg::REQ_LE: form_cmp = !lt_rl;
      default:         form_cmp = 1'b0;
    endcase
  end

  assign mag_a    = mag(a_r);
  assign mag_b    = mag(b_r);
  assign div_t    = {rem_r, quo_r[W-1]};
  assign div_sub  = div_t - {1'b0, dvs_r};
  assign div_ge   = div_t >= {1'b0, dvs_r};
  assign rem_next = div_ge ? div_sub[W-1:0] : div_t[W-1:0];

  always_comb begin
    unique case (cmd.sel)
      rfa_pkg::DIV_REM: begin
        div_dvd = mag_a;
        div_dvs = mag_b;
        div_neg = a_r[W-1];
      end
      rfa_pkg::DIV_QNUM: begin
        div_dvd = mag(num_r);
        div_dvs = mag_a;
        div_neg = num_r[W-1] ^ a_r[W-1];
      end
      default: begin
        div_dvd = mag(den_r);
        div_dvs = mag_a;
        div_neg = den_r[W-1] ^ a_r[W-1];
      end
    endcase
    div_src = (cmd.sel == rfa_pkg::DIV_REM) ? rem_r : quo_r;
    div_res = qneg_r ? (~div_src + 1'b1) : div_src;
  end

  assign st.op_cmp = op_cmp;
  assign st.a_zero = (a_r == '0);
  assign st.b_zero = (b_r == '0);
  assign st.a_lt_b = mag_a < mag_b;

  always_ff @(posedge clk) begin
    unique case (cmd.act)
      rfa_pkg::ACT_LATCH: begin
        op_r <= req_type;
        n1_r <= first_numerator;
        d1_r <= first_denominator;
        n2_r <= second_numerator;
        d2_r <= second_denominator;
      end
      rfa_pkg::ACT_MUL_LOAD: begin
        mcand_r  <= PW'(mag(mul_x));
        mplier_r <= PW'(mag(mul_y));
        acc_r    <= '0;
        mneg_r   <= mul_x[W-1] ^ mul_y[W-1];
      end
      rfa_pkg::ACT_MUL_STEP: begin
        acc_r    <= acc_cat[2*PW+DW-1:DW];
        mplier_r <= mplier_r >> DW;
      end
      rfa_pkg::ACT_MUL_FIX: begin
        unique case (cmd.sel)
          rfa_pkg::PROD_A: begin
            pa_r  <= prod[W-1:0];
            ova_r <= prod_ov;
          end
          rfa_pkg::PROD_B: begin
            pb_r  <= prod[W-1:0];
            ovb_r <= prod_ov;
          end
          default: begin
            pc_r  <= prod[W-1:0];
            ovc_r <= prod_ov;
          end
        endcase
      end
      rfa_pkg::ACT_FORM: begin
        num_r <= form_num;
        den_r <= form_den;
        a_r   <= form_num;
        b_r   <= form_den;
        ov_r  <= form_ov;
        cmp_r <= form_cmp;
      end
      rfa_pkg::ACT_SWAP: begin
        a_r <= b_r;
        b_r <= a_r;
      end
      rfa_pkg::ACT_DIV_LOAD: begin
        rem_r  <= '0;
        quo_r  <= div_dvd;
        dvs_r  <= div_dvs;
        qneg_r <= div_neg;
      end
      rfa_pkg::ACT_DIV_STEP: begin
        rem_r <= rem_next;
        quo_r <= {quo_r[W-2:0], div_ge};
      end
      rfa_pkg::ACT_DIV_END: begin
        unique case (cmd.sel)
          rfa_pkg::DIV_REM: begin
            a_r <= b_r;
            b_r <= div_res;
          end
          rfa_pkg::DIV_QNUM: num_r <= div_res;
          default:           den_r <= div_res;
        endcase
      end
      rfa_pkg::ACT_OUT: begin
        out_num_r  <= op_cmp ? '0 : num_r;
        out_den_r  <= op_cmp ? '0 : den_r;
        out_cmp_r  <= cmp_r;
        out_ov_r   <= ov_r;
        out_zden_r <= !op_cmp && (den_r == '0);
      end
      default: begin
      end
    endcase
  end

  assign result_numerator   = out_num_r;
  assign result_denominator = out_den_r;
  assign compare_true       = out_cmp_r;
  assign overflow           = out_ov_r;
  assign zero_denominator   = out_zden_r;

endmodule
`default_nettype wire

// ----- sv/rfa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational fraction ALU controller
// Sequences products, combine, Euclid loop and reduction; owns the handshakes.
// ----------------------------------------------------------------------------
module rfa_ctrl #(
  parameter int VALUE_WIDTH = rfa_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rfa_pkg::stat_t st,
  output rfa_pkg::cmd_t       cmd
);

  localparam int W      = VALUE_WIDTH;
  localparam int DW     = rfa_pkg::DIGIT_W;
  localparam int DIGITS = (W + DW - 1) / DW;
  localparam int CNT_W  = $clog2(W + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_LOAD = 4'd1;
  localparam logic [3:0] S_MUL_STEP = 4'd2;
  localparam logic [3:0] S_MUL_FIX  = 4'd3;
  localparam logic [3:0] S_FORM     = 4'd4;
  localparam logic [3:0] S_GCD      = 4'd5;
  localparam logic [3:0] S_DIV_LOAD = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_DIV_END  = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd.act   = rfa_pkg::ACT_NONE;
    cmd.sel   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act   = rfa_pkg::ACT_LATCH;
          sel_nxt   = rfa_pkg::PROD_A;
          state_nxt = S_MUL_LOAD;
        end
      end
      S_MUL_LOAD: begin
        cmd.act   = rfa_pkg::ACT_MUL_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        cmd.act = rfa_pkg::ACT_MUL_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIGITS - 1)) begin
          state_nxt = S_MUL_FIX;
        end
      end
      S_MUL_FIX: begin
        cmd.act = rfa_pkg::ACT_MUL_FIX;
        if (sel_r == rfa_pkg::PROD_C) begin
          state_nxt = S_FORM;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_MUL_LOAD;
        end
      end
      S_FORM: begin
        cmd.act   = rfa_pkg::ACT_FORM;
        state_nxt = st.op_cmp ? S_DONE : S_GCD;
      end
      S_GCD: begin
        priority if (st.b_zero) begin
          if (st.a_zero) begin
            state_nxt = S_DONE;
          end else begin
            sel_nxt   = rfa_pkg::DIV_QNUM;
            state_nxt = S_DIV_LOAD;
          end
        end else if (st.a_lt_b) begin
          cmd.act = rfa_pkg::ACT_SWAP;
        end else begin
          sel_nxt   = rfa_pkg::DIV_REM;
          state_nxt = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cmd.act   = rfa_pkg::ACT_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.act = rfa_pkg::ACT_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          state_nxt = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd.act = rfa_pkg::ACT_DIV_END;
        unique case (sel_r)
          rfa_pkg::DIV_REM: state_nxt = S_GCD;
          rfa_pkg::DIV_QNUM: begin
            sel_nxt   = rfa_pkg::DIV_QDEN;
            state_nxt = S_DIV_LOAD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.act   = rfa_pkg::ACT_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.act == rfa_pkg::ACT_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL_LOAD && sel_r == rfa_pkg::PROD_A))
    else $error("accepted item did not start the first product");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == rfa_pkg::ACT_OUT) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result shown without finishing an item");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(W)))
    else $error("divider step count out of range");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_STEP) |-> (cnt_r < CNT_W'(DIGITS)))
    else $error("multiplier digit count out of range");
`endif

endmodule
`default_nettype wire

// ----- sv/rational_fraction_alu_core.sv -----
`default_nettype none
// Each request runs three digit-serial products, the combine, the Euclid remainder
//   divisions with any operand swaps, then the two quotient divisions; compares stop
//   after the combine and 0/0 skips the divisions; a result still held adds a wait.
// The restoring divider retires one quotient bit per cycle.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: synchronous active-low rst_n clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// Rational fraction ALU top level
// Fraction add/sub/mul/div with Euclid GCD reduction, and cross-product compares.
// ----------------------------------------------------------------------------
module rational_fraction_alu_core #(
  parameter int VALUE_WIDTH = rfa_pkg::VALUE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  rfa_in_if.sink   in_ch,
  rfa_out_if.source out_ch
);

  rfa_pkg::cmd_t  cmd;
  rfa_pkg::stat_t st;

  rfa_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  rfa_dpath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .cmd               (cmd),
    .st                (st),
    .req_type          (in_ch.req_type),
    .first_numerator   (in_ch.first_numerator),
    .first_denominator (in_ch.first_denominator),
    .second_numerator  (in_ch.second_numerator),
    .second_denominator(in_ch.second_denominator),
    .result_numerator  (out_ch.result_numerator),
    .result_denominator(out_ch.result_denominator),
    .compare_true      (out_ch.compare_true),
    .overflow          (out_ch.overflow),
    .zero_denominator  (out_ch.zero_denominator)
  );

endmodule
`default_nettype wire

// ----- dv/rational_fraction_alu_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational fraction ALU checker
// Watches both channels, predicts each result from the accepted request and
// compares every field of the results in order. Hands counts to the bench top.
// ----------------------------------------------------------------------------
module rational_fraction_alu_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  rfa_in_if         in_ch,
  rfa_out_if        out_ch,
  output int        fail_count,
  output int        pending,
  output int        checked
);

  localparam int W = rfa_pkg::VALUE_WIDTH_DEF;

  typedef struct packed {
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
    logic                cmp;
    logic                ovf;
    logic                zden;
  } frac_result_t;

  frac_result_t awaited_q[$];
  frac_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic longint fit_width(longint x);
    logic signed [W-1:0] t;
    t = x[W-1:0];
    return longint'(t);
  endfunction

  function automatic longint mul_fit(longint a, longint b, inout bit ovf);
    longint p;
    p = a * b;
    if (p != fit_width(p)) ovf = 1'b1;
    return fit_width(p);
  endfunction

  function automatic longint sum_fit(longint a, longint b, inout bit ovf);
    longint s;
    s = a + b;
    if (s != fit_width(s)) ovf = 1'b1;
    return fit_width(s);
  endfunction

  // Euclid on truncating remainder; result keeps the sign of the last nonzero operand
  function automatic longint trunc_gcd(longint a, longint b);
    longint t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_result_t predict_fraction(logic [2:0] req, longint n1, longint d1,
                                                    longint n2, longint d2);
    frac_result_t r;
    bit           ovf;
    longint       num;
    longint       den;
    longint       g;
    longint       lhs;
    longint       rhs;
    r   = '0;
    ovf = 1'b0;
    num = 0;
    den = 0;
    case (req)
      rfa_pkg::REQ_ADD, rfa_pkg::REQ_SUB: begin
        lhs = mul_fit(n1, d2, ovf);
        rhs = mul_fit(d1, n2, ovf);
        if (req == rfa_pkg::REQ_ADD) num = sum_fit(lhs, rhs, ovf);
        else num = sum_fit(lhs, -rhs, ovf);
        den = mul_fit(d1, d2, ovf);
      end
      rfa_pkg::REQ_MUL: begin
        num = mul_fit(n1, n2, ovf);
        den = mul_fit(d1, d2, ovf);
      end
      rfa_pkg::REQ_DIV: begin
        num = mul_fit(n1, d2, ovf);
        den = mul_fit(d1, n2, ovf);
      end
      default: begin
        lhs = mul_fit(n1, d2, ovf);
        rhs = mul_fit(n2, d1, ovf);
        case (req)
          rfa_pkg::REQ_GT: r.cmp = rhs < lhs;
          rfa_pkg::REQ_GE: r.cmp = !(lhs < rhs);
          rfa_pkg::REQ_LT: r.cmp = lhs < rhs;
          default:         r.cmp = !(rhs < lhs);
        endcase
      end
    endcase
    if (req == rfa_pkg::REQ_ADD || req == rfa_pkg::REQ_SUB ||
        req == rfa_pkg::REQ_MUL || req == rfa_pkg::REQ_DIV) begin
      g = trunc_gcd(num, den);
      if (g != 0) begin
        // most negative over -1 wraps back, no flag
        num = fit_width(num / g);
        den = fit_width(den / g);
      end
      r.num  = num[W-1:0];
      r.den  = den[W-1:0];
      r.zden = (den == 0);
    end
    r.ovf = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_q.push_back(predict_fraction(in_ch.req_type, in_ch.first_numerator,
                                             in_ch.first_denominator, in_ch.second_numerator,
                                             in_ch.second_denominator));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no request outstanding",
                                    out_ch.result_numerator, out_ch.result_denominator));
        end else begin
          want = awaited_q.pop_front();
          if (out_ch.result_numerator !== want.num)
            report_mismatch($sformatf("item %0d numerator got %0d expected %0d", checked,
                                      out_ch.result_numerator, want.num));
          if (out_ch.result_denominator !== want.den)
            report_mismatch($sformatf("item %0d denominator got %0d expected %0d", checked,
                                      out_ch.result_denominator, want.den));
          if (out_ch.compare_true !== want.cmp)
            report_mismatch($sformatf("item %0d compare_true got %b expected %b", checked,
                                      out_ch.compare_true, want.cmp));
          if (out_ch.overflow !== want.ovf)
            report_mismatch($sformatf("item %0d overflow got %b expected %b", checked,
                                      out_ch.overflow, want.ovf));
          if (out_ch.zero_denominator !== want.zden)
            report_mismatch($sformatf("item %0d zero_denominator got %b expected %b", checked,
                                      out_ch.zero_denominator, want.zden));
          checked++;
        end
      end
      pending = awaited_q.size();
    end
  end

endmodule
`default_nettype wire

// ----- dv/rational_fraction_alu_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rational fraction ALU testbench
// Drives directed corner cases and random fraction requests through the core
// with sender and receiver stalls, a long output hold-off and drained pauses;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module rational_fraction_alu_core_tb;

  localparam int     W                = rfa_pkg::VALUE_WIDTH_DEF;
  localparam int     RANDOM_PER_PHASE = 210;
  localparam int     HOLD_CYCLES      = 4000;
  localparam int     HOLD_AT          = 84;
  localparam int     SETTLE_CYCLES    = 2000;
  localparam longint CYCLE_LIMIT      = 4000000;

  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  logic   clk = 1'b0;
  logic   rst_n;
  int     tx_idle_pct = 18;
  int     rx_idle_pct = 70;
  bit     hold_done   = 1'b0;
  int     sent        = 0;
  longint cycles      = 0;
  int     fail_count;
  int     pending;
  int     checked;

  always #5 clk = ~clk;

  rfa_in_if  #(.VALUE_WIDTH(W)) in_ch ();
  rfa_out_if #(.VALUE_WIDTH(W)) out_ch ();

  rational_fraction_alu_core #(.VALUE_WIDTH(W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rational_fraction_alu_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run timed out with %0d results outstanding", pending);
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, and one long hold-off once enough items went in
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(logic [2:0] req, logic signed [W-1:0] n1, logic signed [W-1:0] d1,
                              logic signed [W-1:0] n2, logic signed [W-1:0] d2);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.req_type           <= req;
    in_ch.first_numerator    <= n1;
    in_ch.first_denominator  <= d1;
    in_ch.second_numerator   <= n2;
    in_ch.second_denominator <= d2;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] pick_value();
    logic signed [15:0] half;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return '0;
          1:       return 1;
          2:       return -1;
          3:       return MOST_NEG;
          default: return MOST_POS;
        endcase
      end
      1, 2, 3: return $urandom_range(40) - 20;
      4, 5: begin
        half = 16'($urandom());
        return W'(half);
      end
      default: return $urandom();
    endcase
  endfunction

  initial begin
    rst_n                    <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.req_type           <= rfa_pkg::REQ_ADD;
    in_ch.first_numerator    <= '0;
    in_ch.first_denominator  <= '0;
    in_ch.second_numerator   <= '0;
    in_ch.second_denominator <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_request(rfa_pkg::REQ_ADD, 1, 2, 1, 3);
    send_request(rfa_pkg::REQ_SUB, 1, 2, 1, 3);
    send_request(rfa_pkg::REQ_MUL, 2, 3, 3, 4);
    send_request(rfa_pkg::REQ_DIV, 1, 2, 1, 4);
    send_request(rfa_pkg::REQ_GT, 1, 2, 1, 3);
    send_request(rfa_pkg::REQ_GE, 1, 2, 2, 4);
    send_request(rfa_pkg::REQ_LT, 1, 2, 2, 4);
    send_request(rfa_pkg::REQ_LE, -1, 2, 1, 3);
    send_request(rfa_pkg::REQ_ADD, 1, 2, 1, 2);
    // divide by a zero fraction
    send_request(rfa_pkg::REQ_DIV, 3, 4, 0, 5);
    // 0/0 skips the reduction
    send_request(rfa_pkg::REQ_MUL, 0, 0, 5, 7);
    send_request(rfa_pkg::REQ_ADD, 1, 0, 1, 0);
    // most negative over a gcd of -1
    send_request(rfa_pkg::REQ_MUL, MOST_NEG, -1, 1, 1);
    // negative gcd
    send_request(rfa_pkg::REQ_MUL, -6, 4, 1, 1);
    // consecutive Fibonacci terms: longest Euclid run
    send_request(rfa_pkg::REQ_MUL, 1836311903, 1134903170, 1, 1);
    send_request(rfa_pkg::REQ_ADD, 1, 1, MOST_POS, 1);
    send_request(rfa_pkg::REQ_SUB, MOST_NEG, 1, 1, 1);
    send_request(rfa_pkg::REQ_MUL, MOST_NEG, 1, -1, 1);
    send_request(rfa_pkg::REQ_GT, MOST_POS, 2, 3, 5);
    send_request(rfa_pkg::REQ_LT, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS);
    send_request(rfa_pkg::REQ_ADD, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG);
    send_request(rfa_pkg::REQ_DIV, -1, -1, -1, -1);
    send_request(rfa_pkg::REQ_LE, 0, 0, 0, 0);
    send_request(rfa_pkg::REQ_GE, MOST_NEG, 1, MOST_NEG, 1);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 70 : 0;
      rx_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 18 : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i == RANDOM_PER_PHASE / 2) drain_results();
        send_request(3'($urandom_range(7)), pick_value(), pick_value(), pick_value(),
                     pick_value());
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests: corner cases, then random over all eight ops.", sent);
    $display("%0d results compared under stalls both ways, a %0d-cycle hold-off and drains.",
             checked, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
